### rtl/lsec_pkg.sv
// ----------------------------------------------------------------------------
// lsec_pkg
// shared types and constants for the level-set edge crossing block
// ----------------------------------------------------------------------------
`default_nettype none
package lsec_pkg;
  localparam int DEF_MAX_DIM = 64;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int SIZE_BITS = 7;
  localparam int SPACING_BITS = 20;
  localparam int IDX_BITS = 6;
  localparam int POS_BITS = 26;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_Z = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

### rtl/level_set_edge_crossing.sv
// ----------------------------------------------------------------------------
// level_set_edge_crossing
// zero-crossing finder for a streamed level-set grid
// ----------------------------------------------------------------------------
// Samples arrive z fastest, then y, then x. Each accepted word is compared in
// sign with its x, y and z neighbors (plane store, row store, last sample),
// and each differing edge yields one crossing word, x edge first, with
// last_of_sample set on the final one. In the front end a sample is accepted
// and the stores are read, then each crossing found is issued, then the walk
// advances; in the back end each crossing is popped, its edge fraction is
// found in 17 divider steps, then it is multiplied and output, and it waits
// while the output is stalled. A four-entry queue lets the front end run
// ahead of the divider.
`default_nettype none
module level_set_edge_crossing import lsec_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [SAMPLE_BITS-1:0]   sample_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    crossing_axis,
  output logic [IDX_BITS-1:0]           x_index,
  output logic [IDX_BITS-1:0]           y_index,
  output logic [IDX_BITS-1:0]           z_index,
  output logic [POS_BITS-1:0]           pos_x,
  output logic [POS_BITS-1:0]           pos_y,
  output logic [POS_BITS-1:0]           pos_z,
  output logic                          last_of_sample,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [SPACING_BITS-1:0]  cfg_data
);
  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int JOB_BITS = 2 + 3 * DIM_BITS + 2 * SAMPLE_BITS + 1;

  logic [SIZE_BITS-1:0] size_x, size_y, size_z;
  logic [SPACING_BITS-1:0] spacing_x, spacing_y, spacing_z;
  logic f_valid, q_full, q_ne, q_pop, f_last, b_last;
  logic [1:0] f_axis, b_axis;
  logic [DIM_BITS-1:0] f_xi, f_yi, f_zi, b_xi, b_yi, b_zi;
  logic [SAMPLE_BITS-1:0] f_lo, f_hi, b_lo, b_hi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_BITS'(64);
      size_y <= SIZE_BITS'(64);
      size_z <= SIZE_BITS'(64);
      spacing_x <= SPACING_BITS'(65536);
      spacing_y <= SPACING_BITS'(65536);
      spacing_z <= SPACING_BITS'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_Y: size_y <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_Z: size_z <= cfg_data[SIZE_BITS-1:0];
        REG_SPACING_X: spacing_x <= cfg_data;
        REG_SPACING_Y: spacing_y <= cfg_data;
        REG_SPACING_Z: spacing_z <= cfg_data;
        default: ;
      endcase
    end
  end

  lsec_front #(.MAX_DIM(MAX_DIM), .SAMPLE_BITS(SAMPLE_BITS), .DIM_BITS(DIM_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_sample(sample_value),
    .size_x, .size_y, .size_z,
    .job_valid(f_valid), .job_full(q_full), .job_axis(f_axis),
    .job_xi(f_xi), .job_yi(f_yi), .job_zi(f_zi),
    .job_lo(f_lo), .job_hi(f_hi), .job_last(f_last)
  );

  lsec_queue #(.WIDTH(JOB_BITS), .DEPTH_BITS(2)) u_queue (
    .clk, .rst,
    .push(f_valid),
    .push_data({f_axis, f_xi, f_yi, f_zi, f_lo, f_hi, f_last}),
    .full(q_full),
    .pop(q_pop),
    .pop_data({b_axis, b_xi, b_yi, b_zi, b_lo, b_hi, b_last}),
    .not_empty(q_ne)
  );

  lsec_back #(.SAMPLE_BITS(SAMPLE_BITS), .DIM_BITS(DIM_BITS)) u_back (
    .clk, .rst, .job_ready(q_ne), .job_pop(q_pop),
    .job_axis(b_axis), .job_xi(b_xi), .job_yi(b_yi), .job_zi(b_zi),
    .job_lo(b_lo), .job_hi(b_hi), .job_last(b_last),
    .spacing_x, .spacing_y, .spacing_z,
    .out_valid, .out_stall, .crossing_axis, .x_index, .y_index, .z_index,
    .pos_x, .pos_y, .pos_z, .last_of_sample
  );

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (crossing_axis == AXIS_X || crossing_axis == AXIS_Y ||
                   crossing_axis == AXIS_Z)) else $error("bad crossing axis");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(last_of_sample))
    else $error("stalled crossing word changed");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_pop || q_ne) else $error("queue state inconsistent");
endmodule
`default_nettype wire

### rtl/lsec_front.sv
// ----------------------------------------------------------------------------
// lsec_front
// grid walk, neighbor stores and sign test; pushes one job per crossing
// ----------------------------------------------------------------------------
`default_nettype none
module lsec_front import lsec_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int DIM_BITS = $clog2(MAX_DIM)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SAMPLE_BITS-1:0]  in_sample,
  input  wire logic [SIZE_BITS-1:0]    size_x,
  input  wire logic [SIZE_BITS-1:0]    size_y,
  input  wire logic [SIZE_BITS-1:0]    size_z,
  output logic                         job_valid,
  input  wire logic                    job_full,
  output logic [1:0]                   job_axis,
  output logic [DIM_BITS-1:0]          job_xi,
  output logic [DIM_BITS-1:0]          job_yi,
  output logic [DIM_BITS-1:0]          job_zi,
  output logic [SAMPLE_BITS-1:0]       job_lo,
  output logic [SAMPLE_BITS-1:0]       job_hi,
  output logic                         job_last
);
  localparam int PLANE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int CNT_BITS = DIM_BITS + 1;

  logic [SAMPLE_BITS-1:0] plane_mem [PLANE_DEPTH];
  logic [SAMPLE_BITS-1:0] row_mem [MAX_DIM];
  logic [SAMPLE_BITS-1:0] plane_rd, row_rd, prev_sample, cur;
  logic [DIM_BITS-1:0] x_cnt, y_cnt, z_cnt;
  logic [DIM_BITS-1:0] x_next, y_next, z_next;
  logic busy, dx, dy, dz, sx, sy, sz;
  logic [CNT_BITS-1:0] eff_x, eff_y, eff_z;

  function automatic logic [CNT_BITS-1:0] eff(input logic [SIZE_BITS-1:0] s);
    logic [CNT_BITS-1:0] r;
    if (s < SIZE_BITS'(1)) r = CNT_BITS'(1);
    else if (32'(s) > MAX_DIM) r = CNT_BITS'(MAX_DIM);
    else r = CNT_BITS'(s);
    return r;
  endfunction

  assign eff_x = eff(size_x);
  assign eff_y = eff(size_y);
  assign eff_z = eff(size_z);
  assign in_stall = busy;

  always_comb begin
    z_next = z_cnt;
    y_next = y_cnt;
    x_next = x_cnt;
    if ({1'b0, z_cnt} + CNT_BITS'(1) >= eff_z) begin
      z_next = '0;
      if ({1'b0, y_cnt} + CNT_BITS'(1) >= eff_y) begin
        y_next = '0;
        x_next = ({1'b0, x_cnt} + CNT_BITS'(1) >= eff_x) ? '0 : x_cnt + DIM_BITS'(1);
      end else begin
        y_next = y_cnt + DIM_BITS'(1);
      end
    end else begin
      z_next = z_cnt + DIM_BITS'(1);
    end
  end

  // stores: written on accept, read data registered
  always_ff @(posedge clk) begin
    if (in_valid && !busy) begin
      plane_rd <= plane_mem[{y_cnt, z_cnt}];
      row_rd <= row_mem[z_cnt];
      plane_mem[{y_cnt, z_cnt}] <= in_sample;
      row_mem[z_cnt] <= in_sample;
    end
  end

  // pending edges of the current word
  assign dx = busy && sx && (x_cnt != '0) && (plane_rd[SAMPLE_BITS-1] != cur[SAMPLE_BITS-1]);
  assign dy = busy && sy && (y_cnt != '0) && (row_rd[SAMPLE_BITS-1] != cur[SAMPLE_BITS-1]);
  assign dz = busy && sz && (z_cnt != '0) && (prev_sample[SAMPLE_BITS-1] != cur[SAMPLE_BITS-1]);

  always_comb begin
    job_valid = 1'b0;
    job_axis = AXIS_X;
    job_xi = x_cnt;
    job_yi = y_cnt;
    job_zi = z_cnt;
    job_lo = plane_rd;
    job_hi = cur;
    job_last = 1'b0;
    if (busy) begin
      priority if (dx) begin
        job_valid = 1'b1;
        job_xi = x_cnt - DIM_BITS'(1);
        job_last = !dy && !dz;
      end else if (dy) begin
        job_valid = 1'b1;
        job_axis = AXIS_Y;
        job_yi = y_cnt - DIM_BITS'(1);
        job_lo = row_rd;
        job_last = !dz;
      end else if (dz) begin
        job_valid = 1'b1;
        job_axis = AXIS_Z;
        job_zi = z_cnt - DIM_BITS'(1);
        job_lo = prev_sample;
        job_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy) cur <= in_sample;
    if (rst) begin
      busy <= 1'b0;
      x_cnt <= '0;
      y_cnt <= '0;
      z_cnt <= '0;
      prev_sample <= '0;
      sx <= 1'b0;
      sy <= 1'b0;
      sz <= 1'b0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        sx <= 1'b1;
        sy <= 1'b1;
        sz <= 1'b1;
      end
    end else if (!job_full || !job_valid) begin
      priority if (dx) sx <= 1'b0;
      else if (dy) sy <= 1'b0;
      else if (dz) sz <= 1'b0;
      else begin
        // all edges issued: advance the walk
        busy <= 1'b0;
        prev_sample <= cur;
        x_cnt <= x_next;
        y_cnt <= y_next;
        z_cnt <= z_next;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/lsec_queue.sv
// ----------------------------------------------------------------------------
// lsec_queue
// small fifo between the classifier and the interpolation unit
// ----------------------------------------------------------------------------
`default_nettype none
module lsec_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH_BITS = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);
  logic [WIDTH-1:0] slots [2**DEPTH_BITS];
  logic [DEPTH_BITS-1:0] wr_ptr, rd_ptr;
  logic [DEPTH_BITS:0] count;

  assign full = count[DEPTH_BITS];
  assign not_empty = count != '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && not_empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (DEPTH_BITS+1)'(push && !full) - (DEPTH_BITS+1)'(pop && not_empty);
    end
  end
endmodule
`default_nettype wire

### rtl/lsec_back.sv
// ----------------------------------------------------------------------------
// lsec_back
// radix-2 fraction divider, position multiply and output register
// ----------------------------------------------------------------------------
`default_nettype none
module lsec_back import lsec_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int DIM_BITS = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     job_ready,
  output logic                          job_pop,
  input  wire logic [1:0]               job_axis,
  input  wire logic [DIM_BITS-1:0]      job_xi,
  input  wire logic [DIM_BITS-1:0]      job_yi,
  input  wire logic [DIM_BITS-1:0]      job_zi,
  input  wire logic [SAMPLE_BITS-1:0]   job_lo,
  input  wire logic [SAMPLE_BITS-1:0]   job_hi,
  input  wire logic                     job_last,
  input  wire logic [SPACING_BITS-1:0]  spacing_x,
  input  wire logic [SPACING_BITS-1:0]  spacing_y,
  input  wire logic [SPACING_BITS-1:0]  spacing_z,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    crossing_axis,
  output logic [IDX_BITS-1:0]           x_index,
  output logic [IDX_BITS-1:0]           y_index,
  output logic [IDX_BITS-1:0]           z_index,
  output logic [POS_BITS-1:0]           pos_x,
  output logic [POS_BITS-1:0]           pos_y,
  output logic [POS_BITS-1:0]           pos_z,
  output logic                          last_of_sample
);
  localparam int MAG_BITS = SAMPLE_BITS + 1;
  localparam int QUO_BITS = FRAC_BITS + 1;
  localparam int REM_BITS = MAG_BITS + 1;
  localparam int STEP_BITS = $clog2(QUO_BITS + 1);
  localparam int TERM_BITS = DIM_BITS + FRAC_BITS + 1;
  localparam int PROD_BITS = SPACING_BITS + TERM_BITS;

  bk_state_t state, state_next;
  logic [1:0] axis;
  logic [DIM_BITS-1:0] xi, yi, zi;
  logic last;
  logic a_lsb;
  logic [MAG_BITS-1:0] divisor;
  logic [REM_BITS-1:0] rem, rem_shift, rem_try;
  logic [QUO_BITS-1:0] quo;
  logic [STEP_BITS-1:0] step;
  logic [MAG_BITS-1:0] ma, mb;
  logic [TERM_BITS-1:0] tx, ty, tz;
  logic [PROD_BITS-1:0] px, py, pz;

  function automatic logic [MAG_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
    logic [MAG_BITS-1:0] e;
    e = {v[SAMPLE_BITS-1], v};
    return v[SAMPLE_BITS-1] ? MAG_BITS'(-e) : e;
  endfunction

  function automatic logic [POS_BITS-1:0] sat(input logic [PROD_BITS-1:0] p);
    logic [PROD_BITS-FRAC_BITS-1:0] s;
    s = p[PROD_BITS-1:FRAC_BITS];
    return (s > (PROD_BITS-FRAC_BITS)'({POS_BITS{1'b1}})) ? {POS_BITS{1'b1}}
                                                          : POS_BITS'(s);
  endfunction

  assign ma = mag(job_lo);
  assign mb = mag(job_hi);
  // restoring division of |a|*2^16 by |a|+|b|, one quotient bit a cycle;
  // the dividend's low bits are |a| bit 0 followed by zeros
  assign rem_shift = {rem[REM_BITS-2:0], (step == '0) ? a_lsb : 1'b0};
  assign rem_try = rem_shift - {1'b0, divisor};

  assign tx = {1'b0, xi, FRAC_BITS'(0)} + ((axis == AXIS_X) ? TERM_BITS'(quo) : '0);
  assign ty = {1'b0, yi, FRAC_BITS'(0)} + ((axis == AXIS_Y) ? TERM_BITS'(quo) : '0);
  assign tz = {1'b0, zi, FRAC_BITS'(0)} + ((axis == AXIS_Z) ? TERM_BITS'(quo) : '0);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_ready) state_next = BK_DIV;
      BK_DIV:  if (step == STEP_BITS'(QUO_BITS - 1)) state_next = BK_MUL;
      BK_MUL:  state_next = BK_OUT;
      BK_OUT:  if (!out_valid || !out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = (state == BK_IDLE) && job_ready;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        axis <= job_axis;
        xi <= job_xi;
        yi <= job_yi;
        zi <= job_zi;
        last <= job_last;
        a_lsb <= ma[0];
        divisor <= ma + mb;
        rem <= REM_BITS'(ma[MAG_BITS-1:1]);
        quo <= '0;
        step <= '0;
      end
      BK_DIV: begin
        // shift in the next dividend bit, highest first
        if (!rem_try[REM_BITS-1]) begin
          rem <= rem_try;
          quo <= {quo[QUO_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[QUO_BITS-2:0], 1'b0};
        end
        step <= step + STEP_BITS'(1);
      end
      BK_MUL: begin
        px <= spacing_x * tx;
        py <= spacing_y * ty;
        pz <= spacing_z * tz;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_OUT && (!out_valid || !out_stall)) begin
      crossing_axis <= axis;
      x_index <= IDX_BITS'(xi);
      y_index <= IDX_BITS'(yi);
      z_index <= IDX_BITS'(zi);
      pos_x <= sat(px);
      pos_y <= sat(py);
      pos_z <= sat(pz);
      last_of_sample <= last;
    end
  end
endmodule
`default_nettype wire

### tb/sv/lsec_crossing_checker.sv
// ----------------------------------------------------------------------------
// lsec_crossing_checker
// watches the sample, crossing and register channels, predicts the crossing
// words of every accepted sample and compares them in order
// ----------------------------------------------------------------------------
`default_nettype none
module lsec_crossing_checker import lsec_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire logic [23:0]              sample_value,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire logic [1:0]               crossing_axis,
  input  wire logic [IDX_BITS-1:0]      x_index,
  input  wire logic [IDX_BITS-1:0]      y_index,
  input  wire logic [IDX_BITS-1:0]      z_index,
  input  wire logic [POS_BITS-1:0]      pos_x,
  input  wire logic [POS_BITS-1:0]      pos_y,
  input  wire logic [POS_BITS-1:0]      pos_z,
  input  wire logic                     last_of_sample,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [SPACING_BITS-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]          axis;
    logic [IDX_BITS-1:0] xi;
    logic [IDX_BITS-1:0] yi;
    logic [IDX_BITS-1:0] zi;
    logic [POS_BITS-1:0] px;
    logic [POS_BITS-1:0] py;
    logic [POS_BITS-1:0] pz;
    logic                last;
  } crossing_t;

  crossing_t crossing_q[$];

  logic [SIZE_BITS-1:0]    sz_x, sz_y, sz_z;
  logic [SPACING_BITS-1:0] sp_x, sp_y, sp_z;
  logic [23:0]             plane_mem [0:4095];
  logic [23:0]             row_mem [0:63];
  logic [23:0]             last_sample;
  int                      cx, cy, cz;

  assign pending = crossing_q.size();

  function automatic int grid_len(input logic [SIZE_BITS-1:0] s);
    if (s < 1) return 1;
    if (s > 64) return 64;
    return int'(s);
  endfunction

  function automatic logic [24:0] mag24(input logic [23:0] v);
    if (v[23]) return 25'(25'h1000000 - {1'b0, v});
    return {1'b0, v};
  endfunction

  function automatic logic [POS_BITS-1:0] scaled_pos(input logic [SPACING_BITS-1:0] sp,
                                                     input int idx, input longint frac);
    longint p;
    p = (longint'(sp) * ((longint'(idx) << 16) + frac)) >>> 16;
    if (p > 64'h3FFFFFF) p = 64'h3FFFFFF;
    return p[POS_BITS-1:0];
  endfunction

  function automatic crossing_t edge_crossing(input logic [1:0] axis, input logic [23:0] lo,
                                              input logic [23:0] hi, input int xi,
                                              input int yi, input int zi);
    crossing_t c;
    longint ma, mb, frac;
    ma = longint'(mag24(lo));
    mb = longint'(mag24(hi));
    frac = (ma << 16) / (ma + mb);
    c.axis = axis;
    c.xi = xi[5:0];
    c.yi = yi[5:0];
    c.zi = zi[5:0];
    c.px = scaled_pos(sp_x, xi, axis == AXIS_X ? frac : 0);
    c.py = scaled_pos(sp_y, yi, axis == AXIS_Y ? frac : 0);
    c.pz = scaled_pos(sp_z, zi, axis == AXIS_Z ? frac : 0);
    c.last = 1'b0;
    return c;
  endfunction

  task automatic expect_word(input crossing_t c);
    crossing_q.insert(crossing_q.size(), c);
  endtask

  task automatic predict_sample(input logic [23:0] v);
    int pidx, ridx, first;
    pidx = (cy % 64) * 64 + (cz % 64);
    ridx = cz % 64;
    first = crossing_q.size();
    if (cx > 0 && plane_mem[pidx][23] != v[23])
      expect_word(edge_crossing(AXIS_X, plane_mem[pidx], v, cx - 1, cy, cz));
    if (cy > 0 && row_mem[ridx][23] != v[23])
      expect_word(edge_crossing(AXIS_Y, row_mem[ridx], v, cx, cy - 1, cz));
    if (cz > 0 && last_sample[23] != v[23])
      expect_word(edge_crossing(AXIS_Z, last_sample, v, cx, cy, cz - 1));
    if (crossing_q.size() > first) crossing_q[crossing_q.size() - 1].last = 1'b1;
    plane_mem[pidx] = v;
    row_mem[ridx] = v;
    last_sample = v;
    if (cz + 1 >= grid_len(sz_z)) begin
      cz = 0;
      if (cy + 1 >= grid_len(sz_y)) begin
        cy = 0;
        cx = (cx + 1 >= grid_len(sz_x)) ? 0 : cx + 1;
      end else begin
        cy = cy + 1;
      end
    end else begin
      cz = cz + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sz_x = 64; sz_y = 64; sz_z = 64;
      sp_x = 65536; sp_y = 65536; sp_z = 65536;
      last_sample = '0;
      cx = 0; cy = 0; cz = 0;
      fail_count = 0;
      crossing_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          report_mismatch("unexpected crossing word, axis", crossing_axis, -1);
        end else begin
          crossing_t w;
          w = crossing_q.pop_front();
          if (crossing_axis !== w.axis) report_mismatch("crossing_axis", crossing_axis, w.axis);
          if (x_index !== w.xi) report_mismatch("x_index", x_index, w.xi);
          if (y_index !== w.yi) report_mismatch("y_index", y_index, w.yi);
          if (z_index !== w.zi) report_mismatch("z_index", z_index, w.zi);
          if (pos_x !== w.px) report_mismatch("pos_x", pos_x, w.px);
          if (pos_y !== w.py) report_mismatch("pos_y", pos_y, w.py);
          if (pos_z !== w.pz) report_mismatch("pos_z", pos_z, w.pz);
          if (last_of_sample !== w.last)
            report_mismatch("last_of_sample", last_of_sample, w.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X:    sz_x = cfg_data[SIZE_BITS-1:0];
          REG_SIZE_Y:    sz_y = cfg_data[SIZE_BITS-1:0];
          REG_SIZE_Z:    sz_z = cfg_data[SIZE_BITS-1:0];
          REG_SPACING_X: sp_x = cfg_data;
          REG_SPACING_Y: sp_y = cfg_data;
          REG_SPACING_Z: sp_z = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_sample(sample_value);
    end
  end
endmodule
`default_nettype wire

### tb/sv/tb_level_set_edge_crossing.sv
// ----------------------------------------------------------------------------
// tb_level_set_edge_crossing
// streams whole grids of level-set samples through the crossing finder under
// several register settings and idle patterns; the checker judges each word
// ----------------------------------------------------------------------------
`default_nettype none
module tb_level_set_edge_crossing;
  import lsec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [23:0]             sample_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              crossing_axis;
  logic [IDX_BITS-1:0]     x_index, y_index, z_index;
  logic [POS_BITS-1:0]     pos_x, pos_y, pos_z;
  logic                    last_of_sample;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [SPACING_BITS-1:0] cfg_data = '0;
  int                      fail_count, pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_used = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          gx, gy, gz;

  always #6 clk = ~clk;

  level_set_edge_crossing u_dut (.*);

  lsec_crossing_checker u_chk (.*);

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int dim(input int s);
    if (s < 1) return 1;
    if (s > 64) return 64;
    return s;
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(511)) - 24'd256;
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return $urandom_range(1) ? 24'($urandom_range(3)) : 24'hFFFFFF;
    endcase
  endfunction

  task automatic send_sample(input logic [23:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SPACING_BITS'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_grid(input int sx, input int sy, input int sz,
                          input int px, input int py, input int pz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_SPACING_X, px);
    write_reg(REG_SPACING_Y, py);
    write_reg(REG_SPACING_Z, pz);
    gx = dim(sx); gy = dim(sy); gz = dim(sz);
  endtask

  logic [23:0] directed [26] = '{
    24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
    24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h800000, 24'h000001,
    24'h7FFFFF, 24'hFFFFFF, 24'h012345, 24'hFEDCBA, 24'h000000, 24'h800001,
    24'h7FFFFE, 24'hFFFFFF, 24'h000002, 24'h7FFFFF, 24'h800000, 24'h000000,
    24'hFFFF00, 24'h0000FF
  };

  // sizes per random phase; 0 and 127 exercise the clamped cases
  int ph_sx [8] = '{1, 127, 3, 2, 4, 0, 2, 3};
  int ph_sy [8] = '{0, 1, 4, 3, 2, 32, 2, 2};
  int ph_sz [8] = '{32, 1, 3, 2, 3, 1, 2, 4};

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 2x2x2 then 3x3x2 grids at spacing extremes
    set_grid(2, 2, 2, 20'hFFFFF, 0, 65536);
    for (int i = 0; i < 8; i++) send_sample(directed[i]);
    drain();
    set_grid(3, 3, 2, 65536, 20'hFFFFF, 20'hFFFFF);
    for (int i = 8; i < 26; i++) send_sample(directed[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      case (ph % 3)
        0: set_grid(ph_sx[ph], ph_sy[ph], ph_sz[ph], 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        1: set_grid(ph_sx[ph], ph_sy[ph], ph_sz[ph], 0, 0, 0);
        default: set_grid(ph_sx[ph], ph_sy[ph], ph_sz[ph],
                          $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                          $urandom_range(20'hFFFFF));
      endcase
      n = gx * gy * gz;
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_go <= 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        // pause mid-grid until every crossing word is out
        if (ph == 2 && i == n / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_sample(rand_sample());
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/lsec_pkg.sv
rtl/lsec_front.sv
rtl/lsec_queue.sv
rtl/lsec_back.sv
rtl/level_set_edge_crossing.sv
tb/sv/lsec_crossing_checker.sv
tb/sv/tb_level_set_edge_crossing.sv
